>>> rtl/ccah_pkg.sv
// Shared types, constants and angle table for the compass calibration and heading unit.
package ccah_pkg;

  localparam int HeadingFracBits = 6;
  localparam int CordicStepsReq  = 16;
  localparam int TableLen        = 24;
  localparam int CordicSteps     = (CordicStepsReq > TableLen) ? TableLen : CordicStepsReq;
  localparam int AngBits         = 24;
  localparam int RoundShift      = AngBits - HeadingFracBits;
  localparam int AccW            = 34;
  localparam int VecW            = 36;
  localparam int StepW           = 5;

  localparam logic [2:0]  StatusMask   = 3'h7;
  localparam logic [15:0] CalibReset   = 16'd100;
  localparam logic signed [15:0] MaxReset = -16'sd32768;
  localparam logic signed [15:0] MinReset = 16'sd32767;
  localparam logic signed [AccW-1:0] Acc180 = AccW'(64'd180 << AngBits);
  localparam logic signed [AccW-1:0] Full360 = AccW'(64'd360 << HeadingFracBits);
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(64'd1 << (RoundShift - 1));

  // atan(2^-i) in 2^-24 degree units
  function automatic logic signed [AccW-1:0] atan_entry(input logic [StepW-1:0] i);
    logic signed [AccW-1:0] v;
    v = '0;
    case (i)
      5'd0:  v = 34'sd754974720;
      5'd1:  v = 34'sd445687602;
      5'd2:  v = 34'sd235489088;
      5'd3:  v = 34'sd119537938;
      5'd4:  v = 34'sd60000934;
      5'd5:  v = 34'sd30029717;
      5'd6:  v = 34'sd15018523;
      5'd7:  v = 34'sd7509720;
      5'd8:  v = 34'sd3754917;
      5'd9:  v = 34'sd1877466;
      5'd10: v = 34'sd938734;
      5'd11: v = 34'sd469367;
      5'd12: v = 34'sd234684;
      5'd13: v = 34'sd117342;
      5'd14: v = 34'sd58671;
      5'd15: v = 34'sd29335;
      5'd16: v = 34'sd14668;
      5'd17: v = 34'sd7334;
      5'd18: v = 34'sd3667;
      5'd19: v = 34'sd1833;
      5'd20: v = 34'sd917;
      5'd21: v = 34'sd458;
      5'd22: v = 34'sd229;
      5'd23: v = 34'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

  // work item handed from front to back
  typedef struct packed {
    logic               ready;
    logic               calibrating;
    logic               range_err;
    logic               run;
    logic signed [16:0] cx;
    logic signed [16:0] cy;
    logic [15:0]        rx;
    logic [15:0]        ry;
  } job_t;

endpackage

>>> rtl/ccah_front.sv
// Front end: takes polls, tracks calibration min/max and centers run-phase samples.
module ccah_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [15:0]          cfg_calib_samples,
  input  logic                 in_fire,
  input  logic [7:0]           in_status_byte,
  input  logic [7:0]           in_x_low_byte,
  input  logic [7:0]           in_x_high_byte,
  input  logic [7:0]           in_y_low_byte,
  input  logic [7:0]           in_y_high_byte,
  output ccah_pkg::job_t       job
);
  import ccah_pkg::*;

  logic [15:0]        calib_samples_r;
  logic signed [15:0] x_max_r, x_min_r, y_max_r, y_min_r;
  logic [15:0]        calib_count_r;
  logic               run_phase_r;

  logic               rdy;
  logic signed [15:0] xv, yv;
  logic [15:0]        cnt_nxt;
  logic signed [16:0] sx, sy, mx, my, rxs, rys;

  assign rdy = (in_status_byte[2:0] & StatusMask) != 3'd0 && in_status_byte[0];
  assign xv  = {in_x_high_byte, in_x_low_byte};
  assign yv  = {in_y_high_byte, in_y_low_byte};
  assign cnt_nxt = calib_count_r + 16'd1;

  always_comb begin
    sx  = 17'(x_max_r) + 17'(x_min_r);
    sy  = 17'(y_max_r) + 17'(y_min_r);
    // truncate toward zero
    mx  = (sx + ((sx < 0) ? $signed({16'd0, sx[0]}) : 17'sd0)) >>> 1;
    my  = (sy + ((sy < 0) ? $signed({16'd0, sy[0]}) : 17'sd0)) >>> 1;
    rxs = 17'(x_max_r) - 17'(x_min_r);
    rys = 17'(y_max_r) - 17'(y_min_r);
    job.ready       = rdy;
    job.calibrating = !run_phase_r;
    job.range_err   = rdy && run_phase_r && (rxs <= 0 || rys <= 0);
    job.run         = rdy && run_phase_r && !(rxs <= 0 || rys <= 0);
    job.cx          = 17'(xv) - mx;
    job.cy          = 17'(yv) - my;
    job.rx          = rxs[15:0];
    job.ry          = rys[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_samples_r <= CalibReset;
      x_max_r <= MaxReset;
      x_min_r <= MinReset;
      y_max_r <= MaxReset;
      y_min_r <= MinReset;
      calib_count_r <= '0;
      run_phase_r <= 1'b0;
    end else begin
      if (cfg_valid) calib_samples_r <= cfg_calib_samples;
      if (in_fire && rdy && !run_phase_r) begin
        if (xv < x_min_r) x_min_r <= xv;
        if (xv > x_max_r) x_max_r <= xv;
        if (yv < y_min_r) y_min_r <= yv;
        if (yv > y_max_r) y_max_r <= yv;
        calib_count_r <= cnt_nxt;
        if (cnt_nxt >= calib_samples_r || cnt_nxt == 16'd0) run_phase_r <= 1'b1;
      end
    end
  end
endmodule

>>> rtl/ccah_queue.sv
// Two-entry queue of jobs between front and back.
module ccah_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ccah_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output ccah_pkg::job_t head_job
);
  import ccah_pkg::*;

  job_t       mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head_job  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop) rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> rtl/ccah_back.sv
// Back end: scaling multiplies, iterative CORDIC vectoring, rounding and result register.
module ccah_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_avail,
  input  ccah_pkg::job_t job_in,
  output logic           job_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [14:0]    out_heading,
  output logic           out_heading_valid,
  output logic           out_calibrating,
  output logic           out_sample_taken,
  output logic           out_range_error
);
  import ccah_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ROT, S_FIN} state_t;

  state_t                 state_r;
  job_t                   job_r;
  logic signed [VecW-1:0] x_r, y_r;
  logic signed [AccW-1:0] acc_r;
  logic [StepW-1:0]       step_r;
  logic                   out_valid_r;
  logic [14:0]            heading_r;
  logic                   hv_r, cal_r, st_r, re_r;

  logic signed [34:0]     px, py;
  logic signed [VecW-1:0] dx, dy;
  logic signed [AccW-1:0] hsum, hval;

  assign job_pop = state_r == S_IDLE && job_avail;

  always_comb begin
    px   = job_r.cx * $signed({1'b0, job_r.ry});
    py   = job_r.cy * $signed({1'b0, job_r.rx});
    dx   = y_r >>> step_r;
    dy   = x_r >>> step_r;
    hsum = (acc_r + RoundHalf) >>> RoundShift;
    hval = (hsum <= 0) ? hsum + Full360 : hsum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_FIN) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (job_avail) begin
            job_r   <= job_in;
            acc_r   <= '0;
            step_r  <= '0;
            state_r <= job_in.run ? S_MUL : S_FIN;
          end
        end
        S_MUL: begin
          if (px == 0 && py == 0) begin
            state_r <= S_FIN;
          end else if (px < 0) begin
            x_r     <= -VecW'(px);
            y_r     <= -VecW'(py);
            acc_r   <= Acc180;
            state_r <= S_ROT;
          end else begin
            x_r     <= VecW'(px);
            y_r     <= VecW'(py);
            state_r <= S_ROT;
          end
        end
        S_ROT: begin
          if (y_r < 0) begin
            x_r   <= x_r - dx;
            y_r   <= y_r + dy;
            acc_r <= acc_r - atan_entry(step_r);
          end else begin
            x_r   <= x_r + dx;
            y_r   <= y_r - dy;
            acc_r <= acc_r + atan_entry(step_r);
          end
          step_r <= step_r + 1'b1;
          if (step_r == StepW'(CordicSteps - 1)) state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            heading_r   <= job_r.run ? hval[14:0] : 15'd0;
            hv_r        <= job_r.run;
            cal_r       <= job_r.calibrating;
            st_r        <= job_r.ready;
            re_r        <= job_r.range_err;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_heading       = heading_r;
  assign out_heading_valid = hv_r;
  assign out_calibrating   = cal_r;
  assign out_sample_taken  = st_r;
  assign out_range_error   = re_r;
endmodule

>>> rtl/compass_calibrate_and_heading_unit.sv
// Compass calibration and heading unit: top level.
// One result per poll. Polls enter a two-entry queue, which takes new polls while
// it has room; the back end pops one poll at a time. A poll that needs no heading
// goes from the queue pop straight to the result register; a zero centered vector
// also passes the multiply state; a heading takes the queue pop, the multiply
// state, 16 CORDIC vectoring iterations on a shared add/shift unit and a rounding
// step into the result register, which waits on out_ready. Configuration
// writes are always accepted and must only be issued while the unit is idle.
module compass_calibrate_and_heading_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_calib_samples,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_status_byte,
  input  logic [7:0]  in_x_low_byte,
  input  logic [7:0]  in_x_high_byte,
  input  logic [7:0]  in_y_low_byte,
  input  logic [7:0]  in_y_high_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] out_heading,
  output logic        out_heading_valid,
  output logic        out_calibrating,
  output logic        out_sample_taken,
  output logic        out_range_error
);
  import ccah_pkg::*;

  job_t fe_job, q_job;
  logic q_full, q_avail, q_pop, in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_fire   = in_valid && in_ready;

  ccah_front u_front (
    .clk, .rst_n,
    .cfg_valid,
    .cfg_calib_samples,
    .in_fire,
    .in_status_byte, .in_x_low_byte, .in_x_high_byte, .in_y_low_byte, .in_y_high_byte,
    .job (fe_job)
  );

  ccah_queue u_queue (
    .clk, .rst_n,
    .push      (in_fire),
    .push_job  (fe_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_avail),
    .head_job  (q_job)
  );

  ccah_back u_back (
    .clk, .rst_n,
    .job_avail (q_avail),
    .job_in    (q_job),
    .job_pop   (q_pop),
    .out_valid, .out_ready,
    .out_heading, .out_heading_valid, .out_calibrating,
    .out_sample_taken, .out_range_error
  );
endmodule

>>> rtl/ccah_checker.sv
// Port-level checks for the compass calibration and heading unit.
module ccah_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] out_heading,
  input logic        out_heading_valid,
  input logic        out_sample_taken,
  input logic        out_range_error
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_heading))
    else $error("result beat changed while stalled");

  a_valid_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_heading_valid || out_range_error) |-> out_sample_taken &&
      !(out_heading_valid && out_range_error))
    else $error("heading flags inconsistent");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_heading_valid |-> out_heading != 15'd0 && out_heading <= 15'd23040)
    else $error("heading out of range");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_heading_valid |-> out_heading == 15'd0)
    else $error("heading set without valid");
endmodule

bind compass_calibrate_and_heading_unit ccah_checker u_ccah_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_heading,
  .out_heading_valid, .out_sample_taken, .out_range_error
);
